>>> rtl/rmsp_pkg.sv
// ----------------------------------------------------------------------------
// rmsp_pkg
// shared types and codes for the read memory size profiler
// ----------------------------------------------------------------------------
package rmsp_pkg;

  localparam int FUNC_W   = 3;
  localparam int ID_W     = 16;
  localparam int COST_W   = 32;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 2;
  localparam int RMS_W    = 32;

  typedef enum logic [FUNC_W-1:0] {
    EV_CALL  = 3'd0,
    EV_RET   = 3'd1,
    EV_READ  = 3'd2,
    EV_WRITE = 3'd3,
    EV_ADD   = 3'd4
  } ev_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FRAME    = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RET_RD,
    S_RET_WB,
    S_BYTE_RD,
    S_BYTE_CMP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SRCH_WB,
    S_ADD_RD,
    S_ADD_WB,
    S_RET_PAR,
    S_RET_PWB
  } state_t;

endpackage

>>> rtl/rmsp_ram.sv
// ----------------------------------------------------------------------------
// rmsp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module rmsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rmsp_fifo.sv
// ----------------------------------------------------------------------------
// rmsp_fifo
// short register queue between front and back end
// ----------------------------------------------------------------------------
module rmsp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr && !full) begin
        wp_r <= ~wp_r;
      end
      if (rd && !empty) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(wr && !full) - 2'(rd && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !full && !(rd && !empty)) |=> !empty)
    else $error("queue lost a write");
  assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !wr) |=> empty)
    else $error("queue invented an entry");

endmodule

>>> rtl/rmsp_back.sv
// ----------------------------------------------------------------------------
// rmsp_back
// executes events against the timestamp memory and shadow stack
// ----------------------------------------------------------------------------
module rmsp_back #(
  parameter int STACK_DEPTH = 256,
  parameter int ADDR_WIDTH  = 16,
  parameter int TS_WIDTH    = 32,
  parameter int MAX_LEN     = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ev_valid,
  output logic                            ev_take,
  input  logic [rmsp_pkg::FUNC_W-1:0]     ev_func,
  input  logic [rmsp_pkg::ID_W-1:0]       ev_id,
  input  logic [rmsp_pkg::COST_W-1:0]     ev_cost,
  input  logic [ADDR_WIDTH-1:0]           ev_addr,
  input  logic [$clog2(MAX_LEN+1)-1:0]    ev_len,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [rmsp_pkg::STATUS_W-1:0]   res_status,
  output logic [rmsp_pkg::ID_W-1:0]       res_id,
  output logic [rmsp_pkg::RMS_W-1:0]      res_rms,
  output logic [rmsp_pkg::COST_W-1:0]     res_cost
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int NW = $clog2(MAX_LEN + 1);

  rmsp_pkg::state_t state_r, state_nxt;

  logic [LW-1:0]          level_r, level_nxt;
  logic [TS_WIDTH-1:0]    ctr_r, ctr_nxt;
  logic [ADDR_WIDTH-1:0]  addr_r, addr_nxt;
  logic [NW-1:0]          left_r, left_nxt;
  logic                   rd_r, rd_nxt;
  logic [SW-1:0]          j_r, j_nxt;
  logic [TS_WIDTH-1:0]    bts_r, bts_nxt;
  logic [rmsp_pkg::COST_W-1:0] cost_r, cost_nxt;
  logic [rmsp_pkg::RMS_W-1:0]  crms_r, crms_nxt;
  logic                   rv_r, rv_nxt;
  logic [rmsp_pkg::STATUS_W-1:0] rs_r, rs_nxt;
  logic [rmsp_pkg::ID_W-1:0]     ri_r, ri_nxt;
  logic [rmsp_pkg::RMS_W-1:0]    rr_r, rr_nxt;
  logic [rmsp_pkg::COST_W-1:0]   rc_r, rc_nxt;

  logic                  bt_we;
  logic [ADDR_WIDTH-1:0] bt_wa, bt_ra;
  logic [TS_WIDTH-1:0]   bt_wd, bt_rd;
  logic                  fi_we, ft_we, fr_we, fc_we;
  logic [SW-1:0]         f_wa, f_ra;
  logic [rmsp_pkg::ID_W-1:0]   fi_wd, fi_rd;
  logic [TS_WIDTH-1:0]         ft_wd, ft_rd;
  logic [rmsp_pkg::RMS_W-1:0]  fr_wd, fr_rd;
  logic [rmsp_pkg::COST_W-1:0] fc_wd, fc_rd;
  logic [SW-1:0]               top;

  assign top = SW'(level_r - LW'(1));

  rmsp_ram #(.WIDTH(TS_WIDTH), .DEPTH(2**ADDR_WIDTH)) u_bts (
    .clk, .we(bt_we), .waddr(bt_wa), .wdata(bt_wd), .raddr(bt_ra), .rdata(bt_rd));
  rmsp_ram #(.WIDTH(rmsp_pkg::ID_W), .DEPTH(STACK_DEPTH)) u_fid (
    .clk, .we(fi_we), .waddr(f_wa), .wdata(fi_wd), .raddr(f_ra), .rdata(fi_rd));
  rmsp_ram #(.WIDTH(TS_WIDTH), .DEPTH(STACK_DEPTH)) u_fts (
    .clk, .we(ft_we), .waddr(f_wa), .wdata(ft_wd), .raddr(f_ra), .rdata(ft_rd));
  rmsp_ram #(.WIDTH(rmsp_pkg::RMS_W), .DEPTH(STACK_DEPTH)) u_frms (
    .clk, .we(fr_we), .waddr(f_wa), .wdata(fr_wd), .raddr(f_ra), .rdata(fr_rd));
  rmsp_ram #(.WIDTH(rmsp_pkg::COST_W), .DEPTH(STACK_DEPTH)) u_fcost (
    .clk, .we(fc_we), .waddr(f_wa), .wdata(fc_wd), .raddr(f_ra), .rdata(fc_rd));

  assign res_valid  = rv_r;
  assign res_status = rs_r;
  assign res_id     = ri_r;
  assign res_rms    = rr_r;
  assign res_cost   = rc_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmsp_pkg::S_CLEAR: begin
        if (addr_r == '1) begin
          state_nxt = rmsp_pkg::S_IDLE;
        end
      end
      rmsp_pkg::S_IDLE: begin
        if (ev_valid && !rv_r) begin
          priority case (ev_func)
            rmsp_pkg::EV_RET: begin
              if (level_r != '0) state_nxt = rmsp_pkg::S_RET_RD;
            end
            rmsp_pkg::EV_READ, rmsp_pkg::EV_WRITE: begin
              if (ev_len != '0) state_nxt = rmsp_pkg::S_BYTE_RD;
            end
            rmsp_pkg::EV_ADD: begin
              if (level_r != '0) state_nxt = rmsp_pkg::S_ADD_RD;
            end
            default: ;
          endcase
        end
      end
      rmsp_pkg::S_RET_RD:   state_nxt = rmsp_pkg::S_RET_WB;
      rmsp_pkg::S_RET_WB: begin
        state_nxt = (level_r >= LW'(2)) ? rmsp_pkg::S_RET_PAR : rmsp_pkg::S_CLEAR;
      end
      rmsp_pkg::S_RET_PAR:  state_nxt = rmsp_pkg::S_RET_PWB;
      rmsp_pkg::S_RET_PWB:  state_nxt = rmsp_pkg::S_IDLE;
      rmsp_pkg::S_BYTE_RD:  state_nxt = rmsp_pkg::S_BYTE_CMP;
      rmsp_pkg::S_BYTE_CMP: begin
        if (rd_r && level_r != '0 && bt_rd < ft_rd && bt_rd != '0) begin
          state_nxt = rmsp_pkg::S_SRCH_RD;
        end else if (left_r == NW'(1)) begin
          state_nxt = rmsp_pkg::S_IDLE;
        end else begin
          state_nxt = rmsp_pkg::S_BYTE_RD;
        end
      end
      rmsp_pkg::S_SRCH_RD:  state_nxt = rmsp_pkg::S_SRCH_CMP;
      rmsp_pkg::S_SRCH_CMP: begin
        if (ft_rd <= bts_r) begin
          state_nxt = rmsp_pkg::S_SRCH_WB;
        end else if (j_r == '0) begin
          state_nxt = (left_r == '0) ? rmsp_pkg::S_IDLE : rmsp_pkg::S_BYTE_RD;
        end else begin
          state_nxt = rmsp_pkg::S_SRCH_RD;
        end
      end
      rmsp_pkg::S_SRCH_WB: begin
        state_nxt = (left_r == '0) ? rmsp_pkg::S_IDLE : rmsp_pkg::S_BYTE_RD;
      end
      rmsp_pkg::S_ADD_RD:   state_nxt = rmsp_pkg::S_ADD_WB;
      rmsp_pkg::S_ADD_WB:   state_nxt = rmsp_pkg::S_IDLE;
      default:              state_nxt = rmsp_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    level_nxt = level_r;
    ctr_nxt   = ctr_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    rd_nxt    = rd_r;
    j_nxt     = j_r;
    bts_nxt   = bts_r;
    cost_nxt  = cost_r;
    crms_nxt  = crms_r;
    rv_nxt    = rv_r && !res_ready;
    rs_nxt    = rs_r;
    ri_nxt    = ri_r;
    rr_nxt    = rr_r;
    rc_nxt    = rc_r;
    ev_take   = 1'b0;
    bt_we = 1'b0; bt_wa = addr_r; bt_wd = ctr_r; bt_ra = addr_r;
    fi_we = 1'b0; ft_we = 1'b0; fr_we = 1'b0; fc_we = 1'b0;
    f_wa  = top; f_ra = top;
    fi_wd = ev_id; ft_wd = ctr_r + TS_WIDTH'(1); fr_wd = '0; fc_wd = ev_cost;
    unique case (state_r)
      rmsp_pkg::S_CLEAR: begin
        bt_we    = 1'b1;
        bt_wd    = '0;
        addr_nxt = addr_r + ADDR_WIDTH'(1);
      end
      rmsp_pkg::S_IDLE: begin
        if (ev_valid && !rv_r) begin
          ev_take  = 1'b1;
          addr_nxt = ev_addr;
          left_nxt = ev_len;
          rd_nxt   = (ev_func == rmsp_pkg::EV_READ);
          cost_nxt = ev_cost;
          priority case (ev_func)
            rmsp_pkg::EV_CALL: begin
              if (level_r == LW'(STACK_DEPTH)) begin
                rv_nxt = 1'b1; rs_nxt = rmsp_pkg::ST_OVERFLOW;
                ri_nxt = '0; rr_nxt = '0; rc_nxt = '0;
              end else begin
                f_wa = SW'(level_r);
                fi_we = 1'b1; ft_we = 1'b1; fr_we = 1'b1; fc_we = 1'b1;
                ctr_nxt   = ctr_r + TS_WIDTH'(1);
                level_nxt = level_r + LW'(1);
              end
            end
            rmsp_pkg::EV_RET: begin
              if (level_r == '0) begin
                rv_nxt = 1'b1; rs_nxt = rmsp_pkg::ST_EMPTY;
                ri_nxt = '0; rr_nxt = '0; rc_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      rmsp_pkg::S_RET_RD: ;
      rmsp_pkg::S_RET_WB: begin
        rv_nxt = 1'b1; rs_nxt = rmsp_pkg::ST_FRAME;
        ri_nxt = fi_rd; rr_nxt = fr_rd; rc_nxt = cost_r - fc_rd;
        crms_nxt = fr_rd;
        if (level_r >= LW'(2)) begin
          f_ra = SW'(level_r - LW'(2));
          level_nxt = level_r - LW'(1);
        end else begin
          level_nxt = '0;
          addr_nxt  = '0;
        end
      end
      rmsp_pkg::S_RET_PAR: ;
      rmsp_pkg::S_RET_PWB: begin
        fr_we = 1'b1; fr_wd = fr_rd + crms_r;
      end
      rmsp_pkg::S_BYTE_RD: ;
      rmsp_pkg::S_BYTE_CMP: begin
        bt_we = 1'b1;
        bts_nxt = bt_rd;
        j_nxt   = top;
        f_ra    = top;
        addr_nxt = addr_r + ADDR_WIDTH'(1);
        left_nxt = left_r - NW'(1);
        if (rd_r && level_r != '0 && bt_rd < ft_rd) begin
          fr_we = 1'b1; fr_wd = fr_rd + 32'd1;
        end
      end
      rmsp_pkg::S_SRCH_RD: ;
      rmsp_pkg::S_SRCH_CMP: begin
        if (!(ft_rd <= bts_r)) begin
          j_nxt = j_r - SW'(1);
          f_ra  = j_r - SW'(1);
        end else begin
          f_ra = j_r;
        end
      end
      rmsp_pkg::S_SRCH_WB: begin
        f_wa = j_r; fr_we = 1'b1; fr_wd = fr_rd - 32'd1;
      end
      rmsp_pkg::S_ADD_RD: ;
      rmsp_pkg::S_ADD_WB: begin
        fr_we = 1'b1; fr_wd = fr_rd + 32'd1;
      end
      default: ;
    endcase
    if (state_r == rmsp_pkg::S_SRCH_RD || state_r == rmsp_pkg::S_SRCH_CMP) begin
      if (state_r == rmsp_pkg::S_SRCH_RD) f_ra = j_r;
    end
    if (state_r == rmsp_pkg::S_SRCH_WB) f_ra = j_r;
    if (state_r == rmsp_pkg::S_RET_PAR || state_r == rmsp_pkg::S_RET_PWB) begin
      f_ra = top; f_wa = top;
    end
    // keep frame read on top while a byte is pending
    if (state_r == rmsp_pkg::S_BYTE_RD) f_ra = top;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmsp_pkg::S_CLEAR;
      level_r <= '0;
      ctr_r   <= '0;
      addr_r  <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      ctr_r   <= ctr_nxt;
      addr_r  <= addr_nxt;
      rv_r    <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    rd_r   <= rd_nxt;
    j_r    <= j_nxt;
    bts_r  <= bts_nxt;
    cost_r <= cost_nxt;
    crms_r <= crms_nxt;
    rs_r   <= rs_nxt;
    ri_r   <= ri_nxt;
    rr_r   <= rr_nxt;
    rc_r   <= rc_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) level_r <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (rv_r && !res_ready) |=> (rv_r && $stable(rr_r) && $stable(rs_r)))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    ev_take |-> (state_r == rmsp_pkg::S_IDLE))
    else $error("event taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmsp_pkg::S_RET_WB) |=> rv_r)
    else $error("return produced no record");

endmodule

>>> rtl/rmsp_front.sv
// ----------------------------------------------------------------------------
// rmsp_front
// accepts items, saturates the length and queues them for the back end
// ----------------------------------------------------------------------------
module rmsp_front #(
  parameter int ADDR_WIDTH = 16,
  parameter int MAX_LEN    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [rmsp_pkg::FUNC_W-1:0]   func,
  input  logic [rmsp_pkg::ID_W-1:0]     func_id,
  input  logic [rmsp_pkg::COST_W-1:0]   cost,
  input  logic [rmsp_pkg::ID_W-1:0]     address,
  input  logic [rmsp_pkg::LEN_W-1:0]    length,
  output logic                          ev_valid,
  input  logic                          ev_take,
  output logic [rmsp_pkg::FUNC_W-1:0]   ev_func,
  output logic [rmsp_pkg::ID_W-1:0]     ev_id,
  output logic [rmsp_pkg::COST_W-1:0]   ev_cost,
  output logic [ADDR_WIDTH-1:0]         ev_addr,
  output logic [$clog2(MAX_LEN+1)-1:0]  ev_len
);

  localparam int NW = $clog2(MAX_LEN + 1);
  localparam int EW = rmsp_pkg::FUNC_W + rmsp_pkg::ID_W + rmsp_pkg::COST_W + ADDR_WIDTH + NW;

  logic [NW-1:0]         len_sat;
  logic [ADDR_WIDTH-1:0] addr_w;
  logic [EW-1:0]         wdata, rdata;
  logic                  empty;

  localparam int CW = (rmsp_pkg::LEN_W > NW) ? rmsp_pkg::LEN_W : NW;

  assign len_sat = (CW'(length) > CW'(MAX_LEN)) ? NW'(MAX_LEN) : NW'(length);
  assign addr_w  = ADDR_WIDTH'({{ADDR_WIDTH{1'b0}}, address});
  assign wdata   = {func, func_id, cost, addr_w, len_sat};
  assign {ev_func, ev_id, ev_cost, ev_addr, ev_len} = rdata;
  assign ev_valid = !empty;

  rmsp_fifo #(.WIDTH(EW)) u_q (
    .clk, .rst_n, .wr(push), .wdata, .full, .rd(ev_take), .rdata, .empty);

endmodule

>>> rtl/read_memory_size_profiler_unit.sv
// ----------------------------------------------------------------------------
// read_memory_size_profiler_unit
// per-activation read memory size profiler with shadow call stack
// ----------------------------------------------------------------------------
// Input is a queue: an item enters on push while full is low. Results sit in
// one register: while empty is low the record is on out_*, and pop takes it.
// Calls, reads, writes, adds and undefined kinds give no result; returns,
// overflowing calls and returns on an empty stack give one record.
// A front end queues up to two items; the back end runs one item at a time.
// An add adds one to the top frame's read memory size. A read or write
// handles the bytes of its saturated length one by one; a read byte that
// needs it also walks down the stack frames in an ancestor search over the
// single read port of the frame memories.
// Outermost return and reset start a sweep clearing all 2^ADDR_WIDTH
// addresses of the byte timestamp memory, one address per cycle; items wait
// in the queue meanwhile. A result waiting on pop holds the back end after
// its current item; the input queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module read_memory_size_profiler_unit #(
  parameter int STACK_DEPTH = 256,
  parameter int ADDR_WIDTH  = 16,
  parameter int TS_WIDTH    = 32,
  parameter int MAX_LEN     = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [rmsp_pkg::FUNC_W-1:0]    in_func,
  input  logic [rmsp_pkg::ID_W-1:0]      in_func_id,
  input  logic [rmsp_pkg::COST_W-1:0]    in_cost,
  input  logic [rmsp_pkg::ID_W-1:0]      in_address,
  input  logic [rmsp_pkg::LEN_W-1:0]     in_length,
  output logic                           empty,
  input  logic                           pop,
  output logic [rmsp_pkg::STATUS_W-1:0]  out_status,
  output logic [rmsp_pkg::ID_W-1:0]      out_func_id_res,
  output logic [rmsp_pkg::RMS_W-1:0]     out_rms,
  output logic [rmsp_pkg::COST_W-1:0]    out_cost_res
);

  localparam int NW = $clog2(MAX_LEN + 1);

  logic                        ev_valid, ev_take, res_valid;
  logic [rmsp_pkg::FUNC_W-1:0] ev_func;
  logic [rmsp_pkg::ID_W-1:0]   ev_id;
  logic [rmsp_pkg::COST_W-1:0] ev_cost;
  logic [ADDR_WIDTH-1:0]       ev_addr;
  logic [NW-1:0]               ev_len;

  rmsp_front #(.ADDR_WIDTH(ADDR_WIDTH), .MAX_LEN(MAX_LEN)) u_front (
    .clk, .rst_n, .push, .full,
    .func(in_func), .func_id(in_func_id), .cost(in_cost),
    .address(in_address), .length(in_length),
    .ev_valid, .ev_take, .ev_func, .ev_id, .ev_cost, .ev_addr, .ev_len);

  rmsp_back #(.STACK_DEPTH(STACK_DEPTH), .ADDR_WIDTH(ADDR_WIDTH),
              .TS_WIDTH(TS_WIDTH), .MAX_LEN(MAX_LEN)) u_back (
    .clk, .rst_n, .ev_valid, .ev_take, .ev_func, .ev_id, .ev_cost, .ev_addr,
    .ev_len, .res_valid, .res_ready(pop),
    .res_status(out_status), .res_id(out_func_id_res),
    .res_rms(out_rms), .res_cost(out_cost_res));

  assign empty = !res_valid;

endmodule

>>> test/tb_read_memory_size_profiler_unit.sv
// ----------------------------------------------------------------------------
// tb_read_memory_size_profiler_unit
// Self-checking testbench for the read memory size profiler. A behavioral
// predictor keeps its own byte timestamps and shadow call stack and queues
// the records expected from accepted items. Each popped record is checked
// field by field against the oldest expectation. Directed tests cover the
// empty stack, undefined kinds, wrap, saturation and overflow. Random nested
// sessions then run under varying idle rates and back pressure.
// ----------------------------------------------------------------------------
module tb_read_memory_size_profiler_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 256;
  localparam int ASPACE      = 65536;
  localparam int SAT_LEN     = 64;
  localparam int UNDEF_FIRST = 5;
  localparam int UNDEF_LAST  = 7;
  localparam int WD_LIMIT    = 400000;
  localparam int DRAIN_WAIT  = 70000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    rmsp_pkg::status_t st;
    logic [15:0]       id;
    logic [31:0]       rms;
    logic [31:0]       cost;
  } frame_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [2:0]  in_func = '0;
  logic [15:0] in_func_id = '0;
  logic [31:0] in_cost = '0;
  logic [15:0] in_address = '0;
  logic [6:0]  in_length = '0;
  logic        full, empty;
  logic [1:0]  out_status;
  logic [15:0] out_func_id_res;
  logic [31:0] out_rms, out_cost_res;

  read_memory_size_profiler_unit dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_func(in_func), .in_func_id(in_func_id), .in_cost(in_cost),
    .in_address(in_address), .in_length(in_length),
    .empty(empty), .pop(pop), .out_status(out_status),
    .out_func_id_res(out_func_id_res), .out_rms(out_rms), .out_cost_res(out_cost_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [31:0] byte_ts [ASPACE];
  logic [15:0] fr_id [DEPTH];
  logic [31:0] fr_ts [DEPTH];
  logic [31:0] fr_rms [DEPTH];
  logic [31:0] fr_cost [DEPTH];
  int          level = 0;
  logic [31:0] call_cnt = '0;

  frame_rec_t pending_records[$];
  int errors = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_left = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic predict_event(logic [2:0] f, logic [15:0] id, logic [31:0] c,
                               logic [15:0] a, logic [6:0] l);
    frame_rec_t  r;
    int          n, top;
    logic [15:0] ba;
    logic [31:0] ts;
    n = (l > SAT_LEN) ? SAT_LEN : l;
    case (f)
      rmsp_pkg::EV_CALL: begin
        if (level >= DEPTH) begin
          r = '{rmsp_pkg::ST_OVERFLOW, '0, '0, '0};
          pending_records.push_back(r);
        end else begin
          call_cnt++;
          fr_id[level] = id;
          fr_ts[level] = call_cnt;
          fr_rms[level] = '0;
          fr_cost[level] = c;
          level++;
        end
      end
      rmsp_pkg::EV_RET: begin
        if (level == 0) begin
          r = '{rmsp_pkg::ST_EMPTY, '0, '0, '0};
          pending_records.push_back(r);
        end else begin
          top = level - 1;
          r = '{rmsp_pkg::ST_FRAME, fr_id[top], fr_rms[top], c - fr_cost[top]};
          pending_records.push_back(r);
          if (level >= 2) begin
            fr_rms[top-1] += fr_rms[top];
            level--;
          end else begin
            level = 0;
            foreach (byte_ts[i]) byte_ts[i] = '0;
          end
        end
      end
      rmsp_pkg::EV_READ, rmsp_pkg::EV_WRITE: begin
        for (int i = 0; i < n; i++) begin
          ba = a + i[15:0];
          if (f == rmsp_pkg::EV_READ && level > 0) begin
            top = level - 1;
            ts = byte_ts[ba];
            if (ts < fr_ts[top]) begin
              fr_rms[top]++;
              if (ts != 0) begin
                for (int j = top; j >= 0; j--) begin
                  if (fr_ts[j] <= ts) begin
                    fr_rms[j]--;
                    break;
                  end
                end
              end
            end
          end
          byte_ts[ba] = call_cnt;
        end
      end
      rmsp_pkg::EV_ADD: if (level > 0) fr_rms[level-1]++;
      default: ;
    endcase
  endtask

  task automatic send_item(logic [2:0] f, logic [15:0] id, logic [31:0] c,
                           logic [15:0] a, logic [6:0] l);
    if ($urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    in_func <= f;
    in_func_id <= id;
    in_cost <= c;
    in_address <= a;
    in_length <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_event(f, id, c, a, l);
  endtask

  task automatic send_call(logic [15:0] id, logic [31:0] c);
    send_item(rmsp_pkg::EV_CALL, id, c, $urandom, $urandom);
  endtask

  task automatic send_ret(logic [31:0] c);
    send_item(rmsp_pkg::EV_RET, $urandom, c, $urandom, $urandom);
  endtask

  task automatic send_access(logic [2:0] f, logic [15:0] a, logic [6:0] l);
    send_item(f, $urandom, $urandom, a, l);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    wait (pending_records.size() == 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    frame_rec_t e;
    if (rst_n && pop && !empty) begin
      if (pending_records.size() == 0) begin
        report_mismatch("unexpected record status", out_status, '0);
      end else begin
        e = pending_records.pop_front();
        if (out_status != e.st) report_mismatch("status", out_status, e.st);
        if (out_func_id_res != e.id) report_mismatch("func_id_res", out_func_id_res, e.id);
        if (out_rms != e.rms) report_mismatch("rms", out_rms, e.rms);
        if (out_cost_res != e.cost) report_mismatch("cost_res", out_cost_res, e.cost);
      end
    end
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > WD_LIMIT) begin
      $display("tb_read_memory_size_profiler_unit failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic test_empty_stack();
    send_ret($urandom);
    send_access(rmsp_pkg::EV_READ, $urandom, $urandom_range(1, 127));
    send_access(rmsp_pkg::EV_WRITE, $urandom, $urandom_range(1, 127));
    send_item(rmsp_pkg::EV_ADD, $urandom, $urandom, $urandom, $urandom);
    for (int k = UNDEF_FIRST; k <= UNDEF_LAST; k++)
      send_item(k[2:0], $urandom, $urandom, $urandom, $urandom);
    wait_drained();
  endtask

  task automatic test_nesting_edges();
    send_call(16'hFFFF, 32'hFFFF_FFFF);
    send_access(rmsp_pkg::EV_WRITE, 16'hFFF0, 7'd32);
    send_item(rmsp_pkg::EV_ADD, $urandom, $urandom, $urandom, $urandom);
    send_access(rmsp_pkg::EV_READ, 16'hFFF0, 7'd127);
    send_call(16'h0000, 32'h0000_0010);
    send_access(rmsp_pkg::EV_READ, 16'hFFF0, 7'd8);
    send_access(rmsp_pkg::EV_READ, 16'h0000, 7'd0);
    send_item(UNDEF_LAST, $urandom, $urandom, $urandom, $urandom);
    send_ret(32'h0000_0000);
    send_access(rmsp_pkg::EV_READ, 16'h0005, 7'd64);
    send_ret(32'h1234_5678);
    wait_drained();
  endtask

  task automatic test_overflow();
    for (int k = 0; k < DEPTH; k++) begin
      send_call($urandom, $urandom);
      if (k % 64 == 3)
        send_access(rmsp_pkg::EV_READ, $urandom_range(0, 300), $urandom_range(1, 16));
    end
    send_call($urandom, $urandom);
    send_access(rmsp_pkg::EV_READ, $urandom_range(0, 300), 7'd4);
    for (int k = 0; k < DEPTH; k++) begin
      if (k % 50 == 7)
        send_access(rmsp_pkg::EV_READ, $urandom_range(0, 300), $urandom_range(1, 16));
      send_ret($urandom);
    end
    wait_drained();
  endtask

  task automatic test_back_pressure();
    send_call($urandom, $urandom);
    for (int k = 0; k < 20; k++) send_call($urandom, $urandom);
    hold_req = 1;
    for (int k = 0; k < 20; k++) send_ret($urandom);
    wait_drained();
    send_access(rmsp_pkg::EV_READ, $urandom_range(0, 64), 7'd16);
    send_ret($urandom);
    wait_drained();
  endtask

  task automatic test_random_session(int n_items);
    logic [15:0] base;
    logic [15:0] a;
    logic [6:0]  l;
    int          r;
    base = $urandom;
    send_call($urandom, $urandom);
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      a = ($urandom_range(99) < 80) ? base + $urandom_range(0, 200) : $urandom;
      l = ($urandom_range(99) < 85) ? $urandom_range(0, 12) : $urandom_range(0, 127);
      if (r < 18 && level < 40) send_call($urandom, $urandom);
      else if (r < 34 && level > 1) send_ret($urandom);
      else if (r < 60) send_access(rmsp_pkg::EV_READ, a, l);
      else if (r < 78) send_access(rmsp_pkg::EV_WRITE, a, l);
      else if (r < 90) send_item(rmsp_pkg::EV_ADD, $urandom, $urandom, $urandom, $urandom);
      else if (r < 93) send_item($urandom_range(UNDEF_FIRST, UNDEF_LAST), $urandom, $urandom,
                                 $urandom, $urandom);
      else send_access(rmsp_pkg::EV_READ, a, l);
    end
    while (level > 0) send_ret($urandom);
    wait_drained();
  endtask

  initial begin
    foreach (byte_ts[i]) byte_ts[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_stack();
    test_nesting_edges();
    test_overflow();
    tx_idle = 9;
    rx_idle = 65;
    test_random_session(20);
    tx_idle = 65;
    rx_idle = 9;
    test_random_session(20);
    tx_idle = 0;
    rx_idle = 0;
    test_back_pressure();
    test_random_session(20);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_records.size() == 0) begin
      $display("tb_read_memory_size_profiler_unit passed");
    end else begin
      $display("tb_read_memory_size_profiler_unit failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rmsp_pkg.sv
rtl/rmsp_ram.sv
rtl/rmsp_fifo.sv
rtl/rmsp_back.sv
rtl/rmsp_front.sv
rtl/read_memory_size_profiler_unit.sv
test/tb_read_memory_size_profiler_unit.sv
